[rtl/kpe_pkg.sv]
// Shared types and constants of the k-permutation enumerator.
// No dependencies; used by kpe_free_pick and k_permutation_enumerator_core.
package kpe_pkg;

    localparam int MAX_POSITIONS_DEF = 8;
    localparam int MAX_VALUES_DEF    = 16;

    localparam int DIGIT_W    = 4;
    localparam int LIMIT_W    = 5;
    localparam int IDX_CNT_W  = 4;
    localparam int ITEM_CNT_W = 5;
    localparam int TUPLE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_INDEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ITEM_COUNT  = 2'd1;

    localparam logic [STATUS_W-1:0] STATUS_VALID      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CONFIG_ERR = 2'd2;

    localparam logic [IDX_CNT_W-1:0]  INDEX_COUNT_RST = 4'd4;
    localparam logic [ITEM_CNT_W-1:0] ITEM_COUNT_RST  = 5'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FILL,
        ST_EMIT
    } kpe_state_t;

endpackage

[rtl/kpe_free_pick.sv]
// Shared pick unit: highest value below a limit that is not marked in a used mask.
// Depends on kpe_pkg.
module kpe_free_pick #(
    parameter int NUM_VALUES = kpe_pkg::MAX_VALUES_DEF
) (
    input  logic [NUM_VALUES-1:0]           used_mask,
    input  logic [kpe_pkg::LIMIT_W-1:0]     limit,
    output logic                            found,
    output logic [kpe_pkg::DIGIT_W-1:0]     value
);

    always_comb
    begin
        found = 1'b0;
        value = '0;
        // Ascending scan: the highest free candidate wins.
        for (int v = 0; v < NUM_VALUES; v++)
        begin
            if (!used_mask[v] && (kpe_pkg::LIMIT_W'(v) < limit))
            begin
                found = 1'b1;
                value = kpe_pkg::DIGIT_W'(v);
            end
        end
    end

endmodule

[rtl/k_permutation_enumerator_core.sv]
// Top level of the k-permutation enumerator: sequencer, digit registers, ports.
// Depends on kpe_pkg and kpe_free_pick.
//
//  channel | signals                                   | direction | beat carries
//  --------+-------------------------------------------+-----------+-----------------------
//  s_      | s_tvalid s_tready s_tdata[7:0]            | in        | restart request
//  m_      | m_tvalid m_tready m_tdata m_tuser m_tlast | out       | tuple, status, final
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data    | in        | register write
//
// A restart, a first request, an exhausted request or a bad configuration is
// accepted and then emitted. A next-tuple request adds a search pass and a refill, where
// s (1..index_count) is the number of positions the search pass visits and f (< s)
// the number of lower positions refilled; both passes share one free-value pick unit.
// Reset clears the sequencer, the output valid flag and the start/exhausted flags, and
// loads index_count 4, item_count 8. A stalled output holds the result in the output
// register; the input side is taken again once that result is loaded there.
module k_permutation_enumerator_core #(
    parameter int MAX_POSITIONS = kpe_pkg::MAX_POSITIONS_DEF,
    parameter int MAX_VALUES    = kpe_pkg::MAX_VALUES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // stream in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [0] restart, [7:1] zero
    // stream out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [kpe_pkg::TUPLE_W-1:0]         m_tdata,   // [31:0] tuple_word
    output logic [kpe_pkg::STATUS_W-1:0]        m_tuser,   // [1:0] status
    output logic                                m_tlast,   // final_tuple
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kpe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [kpe_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int POS_W   = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int WIDE_W  = MAX_POSITIONS * kpe_pkg::DIGIT_W;

    // Configuration and control state
    logic [kpe_pkg::IDX_CNT_W-1:0]  index_count_reg, index_count_next;
    logic [kpe_pkg::ITEM_CNT_W-1:0] item_count_reg, item_count_next;
    logic                           started_reg, started_next;
    logic                           exhausted_reg, exhausted_next;
    kpe_pkg::kpe_state_t            state_reg, state_next;
    logic [POS_W-1:0]               pos_reg, pos_next;
    logic [MAX_VALUES-1:0]          used_reg, used_next;
    logic [kpe_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;

    // Digits of the current tuple, position 0 least significant
    logic [kpe_pkg::DIGIT_W-1:0]    digit_reg [MAX_POSITIONS];
    logic [kpe_pkg::DIGIT_W-1:0]    digit_next [MAX_POSITIONS];

    // Output register
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [kpe_pkg::TUPLE_W-1:0]    m_tdata_reg, m_tdata_next;
    logic [kpe_pkg::STATUS_W-1:0]   m_tuser_reg, m_tuser_next;
    logic                           m_tlast_reg, m_tlast_next;

    logic                           in_beat;
    logic                           cfg_ok;
    logic                           out_free;
    logic [kpe_pkg::LIMIT_W-1:0]    k_ext;
    logic [MAX_VALUES-1:0]          search_used;
    logic [MAX_VALUES-1:0]          pick_used;
    logic [kpe_pkg::LIMIT_W-1:0]    pick_limit;
    logic                           pick_found;
    logic [kpe_pkg::DIGIT_W-1:0]    pick_value;
    logic [MAX_VALUES-1:0]          pick_onehot;
    logic                           pos_is_top;
    logic [WIDE_W-1:0]              tuple_wide;
    logic                           is_final;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == kpe_pkg::ST_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign k_ext     = {1'b0, index_count_reg};

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign cfg_ok = (index_count_reg != '0)
                 && (k_ext <= kpe_pkg::LIMIT_W'(MAX_POSITIONS))
                 && (item_count_reg != '0)
                 && (item_count_reg <= kpe_pkg::ITEM_CNT_W'(MAX_VALUES))
                 && (k_ext <= item_count_reg);

    assign pos_is_top = ({{(kpe_pkg::LIMIT_W-POS_W){1'b0}}, pos_reg} == (k_ext - 5'd1));

    // Values held by the positions above the one under search
    always_comb
    begin
        search_used = '0;
        for (int j = 0; j < MAX_POSITIONS; j++)
        begin
            if ((j > int'(pos_reg)) && (j < int'(index_count_reg)))
                search_used = search_used | (MAX_VALUES'(1) << digit_reg[j]);
        end
    end

    // Search looks below the current digit; refill looks below item_count
    assign pick_used  = (state_reg == kpe_pkg::ST_FILL) ? used_reg : search_used;
    assign pick_limit = (state_reg == kpe_pkg::ST_FILL) ? item_count_reg
                                                        : {1'b0, digit_reg[pos_reg]};
    assign pick_onehot = MAX_VALUES'(1) << pick_value;

    kpe_free_pick #(
        .NUM_VALUES (MAX_VALUES)
    ) u_pick (
        .used_mask (pick_used),
        .limit     (pick_limit),
        .found     (pick_found),
        .value     (pick_value)
    );

    // Packed tuple and last-tuple test: the last tuple holds k-1-p at position p
    always_comb
    begin
        tuple_wide = '0;
        is_final   = 1'b1;
        for (int p = 0; p < MAX_POSITIONS; p++)
        begin
            if (p < int'(index_count_reg))
            begin
                tuple_wide[p*kpe_pkg::DIGIT_W +: kpe_pkg::DIGIT_W] = digit_reg[p];
                if ({1'b0, digit_reg[p]} != (k_ext - kpe_pkg::LIMIT_W'(p) - 5'd1))
                    is_final = 1'b0;
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kpe_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (cfg_ok && !s_tdata[0] && started_reg && !exhausted_reg)
                        state_next = kpe_pkg::ST_SEARCH;
                    else
                        state_next = kpe_pkg::ST_EMIT;
                end
            end
            kpe_pkg::ST_SEARCH:
            begin
                if (pick_found)
                    state_next = (pos_reg == '0) ? kpe_pkg::ST_EMIT : kpe_pkg::ST_FILL;
                else if (pos_is_top)
                    state_next = kpe_pkg::ST_EMIT;
            end
            kpe_pkg::ST_FILL:
            begin
                if (pos_reg == '0)
                    state_next = kpe_pkg::ST_EMIT;
            end
            kpe_pkg::ST_EMIT:
            begin
                if (out_free)
                    state_next = kpe_pkg::ST_IDLE;
            end
            default:
                state_next = kpe_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output register
    always_comb
    begin
        index_count_next = index_count_reg;
        item_count_next  = item_count_reg;
        started_next     = started_reg;
        exhausted_next   = exhausted_reg;
        pos_next         = pos_reg;
        used_next        = used_reg;
        res_status_next  = res_status_reg;
        digit_next       = digit_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        m_tlast_next     = m_tlast_reg;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            kpe_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    pos_next = '0;
                    if (!cfg_ok)
                        res_status_next = kpe_pkg::STATUS_CONFIG_ERR;
                    else if (s_tdata[0] || !started_reg)
                    begin
                        // Rewind: position p takes item_count - index_count + p
                        for (int p = 0; p < MAX_POSITIONS; p++)
                            digit_next[p] = kpe_pkg::DIGIT_W'(item_count_reg - k_ext
                                                            + kpe_pkg::LIMIT_W'(p));
                        started_next    = 1'b1;
                        exhausted_next  = 1'b0;
                        res_status_next = kpe_pkg::STATUS_VALID;
                    end
                    else if (exhausted_reg)
                        res_status_next = kpe_pkg::STATUS_EXHAUSTED;
                    else
                        res_status_next = kpe_pkg::STATUS_VALID;
                end
            end
            kpe_pkg::ST_SEARCH:
            begin
                if (pick_found)
                begin
                    digit_next[pos_reg] = pick_value;
                    used_next = search_used | pick_onehot;
                    if (pos_reg != '0)
                        pos_next = pos_reg - 1'b1;
                end
                else if (pos_is_top)
                begin
                    exhausted_next  = 1'b1;
                    res_status_next = kpe_pkg::STATUS_EXHAUSTED;
                end
                else
                    pos_next = pos_reg + 1'b1;
            end
            kpe_pkg::ST_FILL:
            begin
                // Refill lower positions with the largest free values
                digit_next[pos_reg] = pick_value;
                used_next = used_reg | pick_onehot;
                if (pos_reg != '0)
                    pos_next = pos_reg - 1'b1;
            end
            kpe_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    if (res_status_reg == kpe_pkg::STATUS_VALID)
                    begin
                        m_tdata_next = kpe_pkg::TUPLE_W'(tuple_wide);
                        m_tlast_next = is_final;
                    end
                    else
                    begin
                        m_tdata_next = '0;
                        m_tlast_next = 1'b0;
                    end
                end
            end
            default:
            begin
                pos_next = '0;
            end
        endcase

        // Register writes must arrive only while idle (not enforced here); either one rewinds the enumeration
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                kpe_pkg::REG_INDEX_COUNT:
                begin
                    index_count_next = cfg_data[kpe_pkg::IDX_CNT_W-1:0];
                    started_next     = 1'b0;
                    exhausted_next   = 1'b0;
                end
                kpe_pkg::REG_ITEM_COUNT:
                begin
                    item_count_next = cfg_data[kpe_pkg::ITEM_CNT_W-1:0];
                    started_next    = 1'b0;
                    exhausted_next  = 1'b0;
                end
                default:
                begin
                    index_count_next = index_count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= kpe_pkg::ST_IDLE;
            index_count_reg <= kpe_pkg::INDEX_COUNT_RST;
            item_count_reg  <= kpe_pkg::ITEM_COUNT_RST;
            started_reg     <= 1'b0;
            exhausted_reg   <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            index_count_reg <= index_count_next;
            item_count_reg  <= item_count_next;
            started_reg     <= started_next;
            exhausted_reg   <= exhausted_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        used_reg       <= used_next;
        res_status_reg <= res_status_next;
        digit_reg      <= digit_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
        m_tlast_reg    <= m_tlast_next;
    end

endmodule
